>>> rtl/nsf_pkg.sv
// Package for the NMEA sentence framer: character codes, sentence kinds,
// the result record passed between modules and the hex nibble decoder.
// No dependencies.
package nsf_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned POS_W   = 10;
	localparam int unsigned COUNT_W = 11;
	localparam int unsigned KIND_W  = 3;
	localparam int unsigned CAP_LIMIT = 1024;

	localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
	localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
	localparam logic [BYTE_W-1:0] CH_0      = 8'h30;
	localparam logic [BYTE_W-1:0] CH_9      = 8'h39;
	localparam logic [BYTE_W-1:0] CH_A      = 8'h41;
	localparam logic [BYTE_W-1:0] CH_F      = 8'h46;
	localparam logic [BYTE_W-1:0] HEX_TEN   = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_G      = 8'h47;
	localparam logic [BYTE_W-1:0] CH_R      = 8'h52;
	localparam logic [BYTE_W-1:0] CH_M      = 8'h4D;
	localparam logic [BYTE_W-1:0] CH_C      = 8'h43;
	localparam logic [BYTE_W-1:0] CH_I      = 8'h49;
	localparam logic [BYTE_W-1:0] CH_U      = 8'h55;
	localparam logic [BYTE_W-1:0] CH_P      = 8'h50;
	localparam logic [BYTE_W-1:0] CH_D      = 8'h44;

	typedef enum logic [KIND_W-1:0] {
		KIND_UNKNOWN = 3'd0,
		KIND_GGA     = 3'd1,
		KIND_RMC     = 3'd2,
		KIND_IMU     = 3'd3,
		KIND_FPD     = 3'd4
	} kind_t;

	typedef struct packed {
		logic [BYTE_W-1:0]  frame_byte;
		logic [POS_W-1:0]   byte_position;
		logic               frame_end;
		logic               checksum_match;
		logic [BYTE_W-1:0]  received_sum;
		logic [BYTE_W-1:0]  computed_sum;
		kind_t              sentence_kind;
		logic [COUNT_W-1:0] frame_length;
		logic               length_overflow;
	} nsf_result_t;

	// Uppercase hex digits map to their value; anything else passes raw.
	function automatic logic [BYTE_W-1:0] hex_value(input logic [BYTE_W-1:0] c);
		logic [BYTE_W-1:0] v;
		if (c >= CH_0 && c <= CH_9) begin
			v = c - CH_0;
		end else if (c >= CH_A && c <= CH_F) begin
			v = c - CH_A + HEX_TEN;
		end else begin
			v = c;
		end
		return v;
	endfunction

endpackage

>>> rtl/nsf_frame_tracker.sv
// Frame state of the NMEA sentence framer: position count, running XOR,
// checksum decode and type letters, plus the result of the current byte.
// Depends on nsf_pkg.
module nsf_frame_tracker import nsf_pkg::*; #(
	parameter int unsigned FRAME_CAP = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [BYTE_W-1:0] rx_byte,
	output logic              has_result,
	output nsf_result_t       result
);

	localparam logic [COUNT_W-1:0] CAP_C  = COUNT_W'(FRAME_CAP);
	localparam logic [COUNT_W-1:0] LAST_C = COUNT_W'(FRAME_CAP - 1);

	logic               in_frame_q, in_checksum_q, hex_seen_q, overflow_q;
	logic [BYTE_W-1:0]  high_nibble_q, xor_q;
	logic [COUNT_W-1:0] count_q;
	logic [BYTE_W-1:0]  letters_q [3];

	logic               in_frame_d, in_checksum_d, hex_seen_d, overflow_d;
	logic [BYTE_W-1:0]  high_nibble_d, xor_d;
	logic [COUNT_W-1:0] count_d, pos;
	logic [BYTE_W-1:0]  letters_d [3];
	logic [BYTE_W-1:0]  received;
	logic               over, frame_end;
	kind_t              kind;

	always_comb begin
		in_frame_d    = in_frame_q;
		in_checksum_d = in_checksum_q;
		hex_seen_d    = hex_seen_q;
		overflow_d    = overflow_q;
		high_nibble_d = high_nibble_q;
		xor_d         = xor_q;
		count_d       = count_q;
		letters_d     = letters_q;
		received      = '0;
		frame_end     = 1'b0;
		has_result    = 1'b0;
		over          = count_q >= CAP_C;
		pos           = over ? LAST_C : count_q;
		if (!in_frame_q) begin
			if (rx_byte == CH_DOLLAR) begin
				has_result    = 1'b1;
				in_frame_d    = 1'b1;
				in_checksum_d = 1'b0;
				hex_seen_d    = 1'b0;
				high_nibble_d = '0;
				xor_d         = '0;
				count_d       = COUNT_W'(1);
				overflow_d    = 1'b0;
				pos           = '0;
			end
		end else begin
			has_result = 1'b1;
			if (over) begin
				overflow_d = 1'b1;
			end else begin
				if (count_q == COUNT_W'(3)) letters_d[0] = rx_byte;
				if (count_q == COUNT_W'(4)) letters_d[1] = rx_byte;
				if (count_q == COUNT_W'(5)) letters_d[2] = rx_byte;
				count_d = count_q + COUNT_W'(1);
			end
			if (in_checksum_q) begin
				if (!hex_seen_q) begin
					high_nibble_d = hex_value(rx_byte);
					hex_seen_d    = 1'b1;
				end else begin
					received   = {high_nibble_q[3:0], 4'h0} | hex_value(rx_byte);
					frame_end  = 1'b1;
					in_frame_d = 1'b0;
				end
			end else if (rx_byte == CH_STAR) begin
				in_checksum_d = 1'b1;
			end else begin
				xor_d = xor_q ^ rx_byte;
			end
		end
	end

	// A frame shorter than six bytes never wrote all three type letters.
	always_comb begin
		kind = KIND_UNKNOWN;
		if (count_d >= COUNT_W'(6)) begin
			if (letters_d[0] == CH_G && letters_d[1] == CH_G && letters_d[2] == CH_A) begin
				kind = KIND_GGA;
			end else if (letters_d[0] == CH_R && letters_d[1] == CH_M
					&& letters_d[2] == CH_C) begin
				kind = KIND_RMC;
			end else if (letters_d[0] == CH_I && letters_d[1] == CH_M
					&& letters_d[2] == CH_U) begin
				kind = KIND_IMU;
			end else if (letters_d[0] == CH_F && letters_d[1] == CH_P
					&& letters_d[2] == CH_D) begin
				kind = KIND_FPD;
			end
		end
	end

	always_comb begin
		result.frame_byte      = rx_byte;
		result.byte_position   = pos[POS_W-1:0];
		result.frame_end       = frame_end;
		result.checksum_match  = frame_end && (received == xor_d);
		result.received_sum    = received;
		result.computed_sum    = xor_d;
		result.sentence_kind   = frame_end ? kind : KIND_UNKNOWN;
		result.frame_length    = frame_end ? count_d : '0;
		result.length_overflow = overflow_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q    <= 1'b0;
			in_checksum_q <= 1'b0;
			hex_seen_q    <= 1'b0;
			overflow_q    <= 1'b0;
			high_nibble_q <= '0;
			xor_q         <= '0;
			count_q       <= '0;
		end else if (step) begin
			in_frame_q    <= in_frame_d;
			in_checksum_q <= in_checksum_d;
			hex_seen_q    <= hex_seen_d;
			overflow_q    <= overflow_d;
			high_nibble_q <= high_nibble_d;
			xor_q         <= xor_d;
			count_q       <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			letters_q <= letters_d;
		end
	end

endmodule

>>> rtl/nsf_out_reg.sv
// Result register of the NMEA sentence framer with its valid/stall handshake.
// Depends on nsf_pkg.
module nsf_out_reg import nsf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  nsf_result_t load_data,
	input  logic        out_stall,
	output logic        out_valid,
	output logic        busy,
	output nsf_result_t data
);

	logic        valid_s2;
	nsf_result_t data_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_s2 <= load_data;
		end
	end

	assign out_valid = valid_s2;
	assign busy      = valid_s2 && out_stall;
	assign data      = data_s2;

endmodule

>>> rtl/nmea_sentence_framer_core.sv
// NMEA 0183 sentence framer: finds '$'-delimited frames in a byte stream,
// checks the XOR checksum and reports the sentence type at frame end.
// One item is accepted per cycle while the input is not stalled: the byte
// is registered, the frame state updates through short logic, and the
// result is held in an output register. Bytes outside a
// frame, other than '$', produce no result. The input stalls only while
// the output register holds an item that the receiver is stalling.
// Depends on nsf_pkg, nsf_frame_tracker and nsf_out_reg.
module nmea_sentence_framer_core import nsf_pkg::*; #(
	parameter int unsigned MAX_FRAME_BYTES = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [BYTE_W-1:0]  rx_byte,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [BYTE_W-1:0]  frame_byte,
	output logic [POS_W-1:0]   byte_position,
	output logic               frame_end,
	output logic               checksum_match,
	output logic [BYTE_W-1:0]  received_sum,
	output logic [BYTE_W-1:0]  computed_sum,
	output logic [KIND_W-1:0]  sentence_kind,
	output logic [COUNT_W-1:0] frame_length,
	output logic               length_overflow
);

	localparam int unsigned FRAME_CAP =
		(MAX_FRAME_BYTES < CAP_LIMIT) ? MAX_FRAME_BYTES : CAP_LIMIT;

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              advance, has_result, out_busy;
	nsf_result_t       result, held;

	assign advance  = valid_s1 && !out_busy;
	assign in_stall = valid_s1 && out_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	nsf_frame_tracker #(
		.FRAME_CAP(FRAME_CAP)
	) u_tracker (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.rx_byte   (byte_s1),
		.has_result(has_result),
		.result    (result)
	);

	nsf_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance && has_result),
		.load_data(result),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.busy     (out_busy),
		.data     (held)
	);

	assign frame_byte      = held.frame_byte;
	assign byte_position   = held.byte_position;
	assign frame_end       = held.frame_end;
	assign checksum_match  = held.checksum_match;
	assign received_sum    = held.received_sum;
	assign computed_sum    = held.computed_sum;
	assign sentence_kind   = held.sentence_kind;
	assign frame_length    = held.frame_length;
	assign length_overflow = held.length_overflow;

endmodule
